/* src/wotm_pkg.sv */
// Shared constants, register codes and types for the wheel odometry trimmed mean unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package wotm_pkg;
    // history depth per wheel
    localparam int WINDOW = 5;
    localparam int IDX_W  = $clog2(WINDOW);
    // window sum: 32-bit entries plus growth over the window
    localparam int SUM_W  = 32 + $clog2(WINDOW) + 1;
    // step counter wide enough for the 48-step divide
    localparam int CNT_W  = 6;
    localparam int NUM_W  = 48;
    localparam int DEN_W  = 24;

    localparam logic [23:0] CM_PER_COUNT_RST = 24'd531232;
    localparam logic [15:0] TICK_RATE_RST    = 16'd5000;
    localparam logic [15:0] SPEED_LIMIT_RST  = 16'd5000;

    typedef enum logic [1:0] {
        REG_CM_PER_COUNT = 2'd0,
        REG_TICK_RATE    = 2'd1,
        REG_SPEED_LIMIT  = 2'd2
    } wotm_reg_t;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_CLEAR  = 1'b1
    } wotm_op_t;

    // command from the top-level sequencer to one wheel datapath
    typedef struct packed {
        logic                    start;
        logic                    clear;
        logic signed [16:0]      count;
        logic [15:0]             ticks;
        logic [IDX_W-1:0]        slot;
        logic                    do_mean;
    } wotm_cmd_t;
endpackage
`default_nettype wire

/* src/wotm_if.sv */
// Valid/ready channel interfaces for sample items and result items.
// Depends on nothing but plain logic types.
`timescale 1ns / 1ps
`default_nettype none
interface wotm_sample_if;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic signed [15:0] count_left;
    logic signed [15:0] count_right;
    logic [15:0]        elapsed_ticks;
    modport source (output valid, opcode, count_left, count_right, elapsed_ticks,
                    input ready);
    modport sink (input valid, opcode, count_left, count_right, elapsed_ticks,
                  output ready);
endinterface

interface wotm_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] speed_left;
    logic signed [31:0] speed_right;
    logic signed [31:0] speed_mean;
    logic signed [47:0] distance_left;
    logic signed [47:0] distance_right;
    logic signed [47:0] distance_mean;
    logic               window_full;
    modport source (output valid, speed_left, speed_right, speed_mean, distance_left,
                    distance_right, distance_mean, window_full, input ready);
    modport sink (input valid, speed_left, speed_right, speed_mean, distance_left,
                  distance_right, distance_mean, window_full, output ready);
endinterface
`default_nettype wire

/* src/wotm_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on wotm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module wotm_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [wotm_pkg::NUM_W-1:0] num,
    input  wire logic [wotm_pkg::DEN_W-1:0] den,
    output logic                            busy,
    output logic [wotm_pkg::NUM_W-1:0]      quo
);
    import wotm_pkg::*;

    localparam logic [CNT_W-1:0] LAST = CNT_W'(NUM_W - 1);

    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic [DEN_W:0]   trial;
    logic             fits;

    // one trial subtraction per cycle
    always_comb
    begin
        trial    = {rem_reg, quo_reg[NUM_W-1]};
        fits     = trial >= {1'b0, den_reg};
        rem_next = fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
        quo_next = {quo_reg[NUM_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == LAST)
                busy_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;
endmodule
`default_nettype wire

/* src/wotm_wheel.sv */
// One wheel: bit-serial distance and speed products, speed divide, history,
// trimmed mean and distance accumulation. Depends on wotm_pkg and wotm_div.
`timescale 1ns / 1ps
`default_nettype none
module wotm_wheel (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire wotm_pkg::wotm_cmd_t cmd,
    input  wire logic [23:0]        cm_per_count,
    input  wire logic [15:0]        tick_rate_hz,
    input  wire logic [15:0]        speed_limit,
    output logic                    busy,
    output logic signed [31:0]      good_speed,
    output logic signed [47:0]      travel
);
    import wotm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_MUL1, S_DIST, S_MUL2, S_DIVS, S_DIVW, S_SCAN, S_MWAIT
    } state_t;

    localparam logic [CNT_W-1:0] MUL1_LAST = CNT_W'(16);
    localparam logic [CNT_W-1:0] MUL2_LAST = CNT_W'(15);
    localparam logic [CNT_W-1:0] SCAN_LAST = CNT_W'(WINDOW - 1);
    localparam logic [DEN_W-1:0] TRIM_DIV  = DEN_W'(WINDOW - 2);

    state_t                    state_reg;
    logic                      busy_reg;
    logic signed [16:0]        sh_reg;
    logic [47:0]               mcand_reg;
    logic signed [47:0]        acc_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic [15:0]               ticks_reg;
    logic [IDX_W-1:0]          slot_reg;
    logic                      mean_reg;
    logic                      neg_reg;
    logic signed [31:0]        hist_reg [WINDOW];
    logic signed [SUM_W-1:0]   sum_reg;
    logic signed [31:0]        max_reg;
    logic signed [31:0]        min_reg;
    logic signed [31:0]        good_reg;
    logic signed [47:0]        travel_reg;

    logic                      div_start;
    logic [NUM_W-1:0]          div_num;
    logic [DEN_W-1:0]          div_den;
    logic                      div_busy;
    logic [NUM_W-1:0]          div_quo;

    logic signed [47:0]        p_rnd;
    logic signed [31:0]        samp_dist;
    logic signed [48:0]        tsum;
    logic signed [47:0]        travel_next;
    logic signed [31:0]        speed_sat;
    logic signed [31:0]        elem;
    logic signed [SUM_W-1:0]   trim;
    logic signed [31:0]        mean_val;

    wotm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .quo   (div_quo)
    );

    // rounding, travel saturation, speed saturation and window scan
    always_comb
    begin
        p_rnd     = acc_reg + 48'sd128;
        samp_dist = p_rnd[39:8];
        tsum      = {travel_reg[47], travel_reg} + 49'(samp_dist);
        if (tsum[48] != tsum[47])
            travel_next = tsum[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
        else
            travel_next = tsum[47:0];
        if (!neg_reg)
            speed_sat = (|div_quo[47:31]) ? 32'sh7FFF_FFFF : $signed(div_quo[31:0]);
        else
            speed_sat = (|div_quo[47:31]) ? 32'sh8000_0000 : -$signed(div_quo[31:0]);
        elem     = hist_reg[cnt_reg[IDX_W-1:0]];
        trim     = sum_reg - SUM_W'(max_reg) - SUM_W'(min_reg);
        mean_val = neg_reg ? -$signed(div_quo[31:0]) : $signed(div_quo[31:0]);
    end

    // divider request: speed divide or trimmed-mean divide
    always_comb
    begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        if (state_reg == S_DIVS)
        begin
            div_start = 1'b1;
            div_num   = acc_reg[47] ? NUM_W'(-acc_reg) : NUM_W'(acc_reg);
            div_den   = {ticks_reg, 8'h00};
        end
        else if (state_reg == S_SCAN && cnt_reg == SCAN_LAST)
        begin
            // final trim is formed from the last element in the next cycle, so
            // the start is issued from S_MWAIT entry below instead
            div_start = 1'b0;
        end
        else if (state_reg == S_MWAIT && !busy_reg)
        begin
            div_start = 1'b0;
        end
        if (state_reg == S_MWAIT && mean_reg)
        begin
            div_start = 1'b1;
            div_num   = trim[SUM_W-1] ? NUM_W'(-trim) : NUM_W'(trim);
            div_den   = TRIM_DIV;
        end
    end

    // sequencer and datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            busy_reg   <= 1'b0;
            good_reg   <= '0;
            travel_reg <= '0;
            mean_reg   <= 1'b0;
            for (int i = 0; i < WINDOW; i++)
                hist_reg[i] <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd.clear)
                        travel_reg <= '0;
                    if (cmd.start)
                    begin
                        sh_reg    <= cmd.count;
                        mcand_reg <= 48'(cm_per_count);
                        acc_reg   <= '0;
                        cnt_reg   <= '0;
                        ticks_reg <= cmd.ticks;
                        slot_reg  <= cmd.slot;
                        mean_reg  <= 1'b0;
                        neg_reg   <= cmd.do_mean;
                        busy_reg  <= 1'b1;
                        state_reg <= S_MUL1;
                    end
                end
                // count x cm_per_count, count bit 16 carries negative weight
                S_MUL1:
                begin
                    if (sh_reg[0])
                        acc_reg <= (cnt_reg == MUL1_LAST) ? acc_reg - $signed(mcand_reg)
                                                          : acc_reg + $signed(mcand_reg);
                    sh_reg    <= sh_reg >>> 1;
                    mcand_reg <= mcand_reg << 1;
                    cnt_reg   <= cnt_reg + 1'b1;
                    if (cnt_reg == MUL1_LAST)
                        state_reg <= S_DIST;
                end
                S_DIST:
                begin
                    travel_reg <= travel_next;
                    mean_reg   <= neg_reg;
                    if (ticks_reg == 16'd0)
                    begin
                        busy_reg  <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        mcand_reg <= 48'(samp_dist);
                        acc_reg   <= '0;
                        sh_reg    <= {1'b0, tick_rate_hz};
                        cnt_reg   <= '0;
                        state_reg <= S_MUL2;
                    end
                end
                // distance x tick rate
                S_MUL2:
                begin
                    if (sh_reg[0])
                        acc_reg <= acc_reg + $signed(mcand_reg);
                    sh_reg    <= sh_reg >>> 1;
                    mcand_reg <= mcand_reg << 1;
                    cnt_reg   <= cnt_reg + 1'b1;
                    if (cnt_reg == MUL2_LAST)
                        state_reg <= S_DIVS;
                end
                S_DIVS:
                begin
                    neg_reg   <= acc_reg[47];
                    state_reg <= S_DIVW;
                end
                S_DIVW:
                begin
                    if (!div_busy)
                    begin
                        hist_reg[slot_reg] <= speed_sat;
                        if (mean_reg)
                        begin
                            sum_reg   <= '0;
                            max_reg   <= 32'sh8000_0000;
                            min_reg   <= 32'sh7FFF_FFFF;
                            cnt_reg   <= '0;
                            state_reg <= S_SCAN;
                        end
                        else
                        begin
                            busy_reg  <= 1'b0;
                            state_reg <= S_IDLE;
                        end
                    end
                end
                // sum, max and min over the window, one entry a cycle
                S_SCAN:
                begin
                    sum_reg <= sum_reg + SUM_W'(elem);
                    if (elem > max_reg)
                        max_reg <= elem;
                    if (elem < min_reg)
                        min_reg <= elem;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == SCAN_LAST)
                    begin
                        mean_reg  <= 1'b1;
                        state_reg <= S_MWAIT;
                    end
                end
                // first cycle launches the divide, then wait for the quotient
                S_MWAIT:
                begin
                    if (mean_reg)
                    begin
                        neg_reg  <= trim[SUM_W-1];
                        mean_reg <= 1'b0;
                    end
                    else if (!div_busy)
                    begin
                        if (33'(mean_val) < $signed({9'b0, speed_limit, 8'b0}))
                            good_reg <= mean_val;
                        busy_reg  <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                    busy_reg  <= 1'b0;
                end
            endcase
        end
    end

    assign busy       = busy_reg;
    assign good_speed = good_reg;
    assign travel     = travel_reg;
endmodule
`default_nettype wire

/* src/wheel_odometry_trimmed_mean_unit.sv */
// Top level of the wheel odometry trimmed mean unit: configuration registers,
// window bookkeeping and result channel. Depends on wotm_pkg, wotm_if, wotm_wheel.
//
// Usage:
//   sample (valid/ready) carries opcode, both encoder counts and elapsed ticks.
//   result (valid/ready) carries filtered speeds, accumulated distances, their
//   means and the window-full flag; one result item per sample item.
//   Configuration is a write port (cfg_we, cfg_index, cfg_data), written while idle.
// Steps per item, one item at a time, both wheels in lockstep:
//   clear item: result valid in the cycle after acceptance.
//   zero ticks: 17-step count product plus accumulate.
//   window filling: count product, 16-step rate product, 48-step speed divide.
//   window full: adds a 5-entry scan and a second 48-step
//   divide for the trimmed mean.
// sample.ready is high only while no item is in work and no result is waiting;
// a stalled result holds until taken. Reset loads register defaults, empties the
// history and zeroes speeds and distances.
`timescale 1ns / 1ps
`default_nettype none
module wheel_odometry_trimmed_mean_unit (
    input  wire logic         clk,
    input  wire logic         rst_n,
    wotm_sample_if.sink       sample,
    wotm_result_if.source     result,
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [23:0]  cfg_data
);
    import wotm_pkg::*;

    typedef enum logic [1:0] {T_IDLE, T_RUN, T_OUT} state_t;

    state_t            state_reg;
    logic [23:0]       cpc_reg;
    logic [15:0]       rate_reg;
    logic [15:0]       limit_reg;
    logic [IDX_W-1:0]  slot_reg;
    logic              filled_reg;
    logic              accept;
    logic              slot_wrap;
    wotm_cmd_t         cmd;
    logic              busy_l;
    logic              busy_r;
    logic signed [31:0] speed_l;
    logic signed [31:0] speed_r;
    logic signed [47:0] travel_l;
    logic signed [47:0] travel_r;
    logic signed [32:0] ssum;
    logic signed [32:0] sadj;
    logic signed [48:0] dsum;
    logic signed [48:0] dadj;

    assign accept    = sample.valid && sample.ready;
    assign slot_wrap = (32'(slot_reg) + 32'd1) >= 32'(WINDOW);

    // wheel command built from the accepted item
    always_comb
    begin
        cmd.start   = accept && (sample.opcode == OP_SAMPLE);
        cmd.clear   = accept && (sample.opcode == OP_CLEAR);
        cmd.count   = '0;
        cmd.ticks   = sample.elapsed_ticks;
        cmd.slot    = slot_reg;
        cmd.do_mean = filled_reg || slot_wrap;
    end

    wotm_cmd_t cmd_l;
    wotm_cmd_t cmd_r;
    always_comb
    begin
        cmd_l       = cmd;
        cmd_l.count = {sample.count_left[15], sample.count_left};
        cmd_r       = cmd;
        cmd_r.count = -$signed({sample.count_right[15], sample.count_right});
    end

    wotm_wheel u_left (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd_l),
        .cm_per_count (cpc_reg),
        .tick_rate_hz (rate_reg),
        .speed_limit  (limit_reg),
        .busy         (busy_l),
        .good_speed   (speed_l),
        .travel       (travel_l)
    );

    wotm_wheel u_right (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd_r),
        .cm_per_count (cpc_reg),
        .tick_rate_hz (rate_reg),
        .speed_limit  (limit_reg),
        .busy         (busy_r),
        .good_speed   (speed_r),
        .travel       (travel_r)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpc_reg   <= CM_PER_COUNT_RST;
            rate_reg  <= TICK_RATE_RST;
            limit_reg <= SPEED_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CM_PER_COUNT: cpc_reg   <= cfg_data;
                REG_TICK_RATE:    rate_reg  <= cfg_data[15:0];
                REG_SPEED_LIMIT:  limit_reg <= cfg_data[15:0];
                default:          ;
            endcase
        end
    end

    // sequencer and window bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= T_IDLE;
            slot_reg   <= '0;
            filled_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                T_IDLE:
                begin
                    if (accept)
                    begin
                        if (sample.opcode == OP_CLEAR)
                            state_reg <= T_OUT;
                        else
                        begin
                            state_reg <= T_RUN;
                            if (sample.elapsed_ticks != 16'd0)
                            begin
                                if (slot_wrap)
                                begin
                                    slot_reg   <= '0;
                                    filled_reg <= 1'b1;
                                end
                                else
                                    slot_reg <= slot_reg + 1'b1;
                            end
                        end
                    end
                end
                T_RUN:
                begin
                    if (!busy_l && !busy_r)
                        state_reg <= T_OUT;
                end
                T_OUT:
                begin
                    if (result.ready)
                        state_reg <= T_IDLE;
                end
                default: state_reg <= T_IDLE;
            endcase
        end
    end

    // means truncated toward zero
    always_comb
    begin
        ssum = 33'(speed_l) + 33'(speed_r);
        sadj = ssum + {32'b0, ssum[32] & ssum[0]};
        dsum = 49'(travel_l) + 49'(travel_r);
        dadj = dsum + {48'b0, dsum[48] & dsum[0]};
    end

    assign sample.ready          = (state_reg == T_IDLE);
    assign result.valid          = (state_reg == T_OUT);
    assign result.speed_left     = speed_l;
    assign result.speed_right    = speed_r;
    assign result.speed_mean     = sadj[32:1];
    assign result.distance_left  = travel_l;
    assign result.distance_right = travel_r;
    assign result.distance_mean  = dadj[48:1];
    assign result.window_full    = filled_reg;
endmodule
`default_nettype wire
